// ===== hdl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16/USB byte step for the sensor frame receiver.
// No dependencies; the top level and the checker refer to it by scoped names.
package sfr_pkg;

   // Default depth of the record FIFO.
   localparam int FIFO_DEPTH_DEF = 4;

   // Action codes carried by the request channel.
   localparam logic [1:0] ACT_BYTE = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SOF_FIRST     = 2'd0;
   localparam logic [1:0] CSR_SOF_SECOND    = 2'd1;
   localparam logic [1:0] CSR_VALUE_COUNT   = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd3;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // Configuration reset values.
   localparam logic [7:0]  SOF_FIRST_RST     = 8'hDD;
   localparam logic [7:0]  SOF_SECOND_RST    = 8'h16;
   localparam logic [3:0]  VALUE_COUNT_RST   = 4'd3;
   localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd7500;

   // Frame layout.
   localparam logic [3:0] FRAME_LEN   = 4'd12;
   localparam logic [3:0] CRC_LEN     = 4'd10;
   localparam logic [3:0] POS_COUNT   = 4'd3;
   localparam logic [3:0] POS_CRC_LO  = 4'd10;
   localparam logic [3:0] POS_REC_LO  = 4'd2;
   localparam int         REC_BYTES   = 8;
   localparam int         REC_W       = 64;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_XOR  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // Status of one result while it travels to the output register.
   typedef struct packed {
      logic [2:0] fifo_count;
      logic       record_valid;
      logic       frame_accepted;
      logic       frame_dropped;
   } rsp_meta_type;

   // One byte of the reflected CRC-16/USB, bit by bit.
   function automatic logic [15:0] crc16_step(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] crc;
      crc = crc_i ^ {8'h00, data_i};
      for (int b = 0; b < 8; b++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

endpackage

// ===== hdl/sfr_req_if.sv =====
`timescale 1ns / 1ps
// Request channel of the sensor frame receiver: valid/ready plus one action.
// Depends on nothing.
interface sfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] action;
   logic [7:0] rx_byte;
   logic       framing_error;

   modport source (output valid, output action, output rx_byte, output framing_error,
                   input ready);
   modport sink   (input valid, input action, input rx_byte, input framing_error,
                   output ready);
endinterface

// ===== hdl/sfr_rsp_if.sv =====
`timescale 1ns / 1ps
// Response channel of the sensor frame receiver: valid/ready plus one result.
// Depends on nothing.
interface sfr_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  fifo_count;
   logic [63:0] record;
   logic        record_valid;
   logic        frame_accepted;
   logic        frame_dropped;

   modport source (output valid, output fifo_count, output record, output record_valid,
                   output frame_accepted, output frame_dropped, input ready);
   modport sink   (input valid, input fifo_count, input record, input record_valid,
                   input frame_accepted, input frame_dropped, output ready);
endinterface

// ===== hdl/sfr_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module sfr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/sensor_frame_receiver_fifo.sv =====
`timescale 1ns / 1ps
// Top level of the sensor frame receiver with its record FIFO.
// Depends on sfr_pkg, sfr_req_if, sfr_rsp_if and sfr_ram.
//
//  channel   | direction | handshake     | carries
//  ----------+-----------+---------------+----------------------------------------------
//  req_chan  | in        | valid / ready | action, rx_byte, framing_error
//  rsp_chan  | out       | valid / ready | fifo_count, record, record_valid, flags
//  csr_*     | in        | csr_we only   | csr_index, csr_wdata (four registers)
//
// One request transfer is taken every cycle while req_chan.ready is high; each gives
// exactly one response transfer, which first waits for the registered RAM read port.
// Between the request side and the response port sit two registers (a result stage that
// waits for the RAM data and the output register), so a stalled response only blocks
// requests once both are full.
// Reset is synchronous and clears the frame state, the FIFO pointers and both stages;
// the record RAM itself is never cleared, since an entry is only read after a push.
module sensor_frame_receiver_fifo #(
   parameter int FIFO_DEPTH = sfr_pkg::FIFO_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   sfr_req_if.sink                            req_chan,
   sfr_rsp_if.source                          rsp_chan,
   input  logic                               csr_we,
   input  logic [sfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int REC_W = sfr_pkg::REC_W;

   // Configuration registers.
   logic [7:0]  sof_first_ff, sof_second_ff;
   logic [3:0]  value_count_ff;
   logic [15:0] timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sof_first_ff     <= sfr_pkg::SOF_FIRST_RST;
         sof_second_ff    <= sfr_pkg::SOF_SECOND_RST;
         value_count_ff   <= sfr_pkg::VALUE_COUNT_RST;
         timeout_ticks_ff <= sfr_pkg::TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            sfr_pkg::CSR_SOF_FIRST:     sof_first_ff     <= csr_wdata[7:0];
            sfr_pkg::CSR_SOF_SECOND:    sof_second_ff    <= csr_wdata[7:0];
            sfr_pkg::CSR_VALUE_COUNT:   value_count_ff   <= csr_wdata[3:0];
            sfr_pkg::CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Frame assembly state. The record bytes (frame bytes 2 to 9) are collected in place
   // as they arrive, together with the low CRC byte and the count nibble, so the final
   // check at byte twelve needs no read-back of earlier bytes. The count nibble is
   // compared against the register value current at byte twelve.
   logic [3:0]       frame_index_ff, frame_index_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      timer_count_ff, timer_count_in;
   logic             timer_armed_ff, timer_armed_in;
   logic [REC_W-1:0] rec_asm_ff, rec_asm_in;
   logic [7:0]       crc_lo_ff, crc_lo_in;
   logic [3:0]       count_nib_ff, count_nib_in;

   // Record FIFO bookkeeping.
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;

   // Result stage (waits for RAM data) and output register.
   logic                  s1_valid_ff, s1_valid_in;
   sfr_pkg::rsp_meta_type s1_meta_ff, s1_meta_in;
   logic                  out_valid_ff, out_valid_in;
   sfr_pkg::rsp_meta_type out_meta_ff, out_meta_in;
   logic [REC_W-1:0]      out_record_ff, out_record_in;

   logic             req_take, s1_move;
   logic             push, pop;
   logic [REC_W-1:0] ram_rd_data;

   logic [3:0]       pos, next_pos;
   logic [15:0]      crc_base, crc_step_val, crc_final, tick_count;
   logic             crc_pass;
   logic [CNT_W+2:0] fill_ext;

   // A result leaves the result stage when the output register is empty or drains.
   assign s1_move        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_move;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      pos          = (frame_index_ff >= sfr_pkg::FRAME_LEN) ? 4'd0 : frame_index_ff;
      next_pos     = pos + 4'd1;
      crc_base     = (pos == 4'd0) ? sfr_pkg::CRC_INIT : crc_ff;
      crc_step_val = sfr_pkg::crc16_step(crc_base, req_chan.rx_byte);
      crc_final    = crc_ff ^ sfr_pkg::CRC_XOR;
      crc_pass     = (crc_final[7:0] == crc_lo_ff) && (crc_final[15:8] == req_chan.rx_byte)
                     && (count_nib_ff == value_count_ff);
      tick_count   = timer_count_ff + 16'd1;
   end

   // Next state of the frame, timer and FIFO bookkeeping for one accepted transfer.
   always_comb begin
      frame_index_in = frame_index_ff;
      crc_in         = crc_ff;
      timer_count_in = timer_count_ff;
      timer_armed_in = timer_armed_ff;
      rec_asm_in     = rec_asm_ff;
      crc_lo_in      = crc_lo_ff;
      count_nib_in   = count_nib_ff;
      wr_ptr_in      = wr_ptr_ff;
      rd_ptr_in      = rd_ptr_ff;
      fill_in        = fill_ff;
      push           = 1'b0;
      pop            = 1'b0;
      s1_meta_in     = '0;

      if (req_take) begin
         unique case (req_chan.action)
            sfr_pkg::ACT_BYTE: begin
               // A record, low CRC or count byte is stored, and a byte ahead of the CRC field
               // is folded into the CRC, even on a framing error; only then are the checks applied.
               for (int i = 0; i < sfr_pkg::REC_BYTES; i++) begin
                  if (pos == sfr_pkg::POS_REC_LO + 4'(i)) begin
                     rec_asm_in[8*i +: 8] = req_chan.rx_byte;
                  end
               end
               if (pos == sfr_pkg::POS_CRC_LO) begin
                  crc_lo_in = req_chan.rx_byte;
               end
               if (pos == sfr_pkg::POS_COUNT) begin
                  count_nib_in = req_chan.rx_byte[7:4];
               end
               crc_in = (pos < sfr_pkg::CRC_LEN) ? crc_step_val : crc_base;

               priority if (req_chan.framing_error) begin
                  frame_index_in = 4'd0;
               end else if ((next_pos == 4'd1 && req_chan.rx_byte != sof_first_ff) ||
                            (next_pos == 4'd2 && req_chan.rx_byte != sof_second_ff)) begin
                  frame_index_in = 4'd0;
               end else if (next_pos == 4'd1) begin
                  // The first byte of a frame rearms the timeout from zero.
                  frame_index_in = next_pos;
                  timer_armed_in = 1'b1;
                  timer_count_in = 16'd0;
               end else if (next_pos >= sfr_pkg::FRAME_LEN) begin
                  frame_index_in = 4'd0;
                  if (crc_pass) begin
                     s1_meta_in.frame_accepted = 1'b1;
                     if (fill_ff == CNT_W'(FIFO_DEPTH)) begin
                        s1_meta_in.frame_dropped = 1'b1;
                     end else begin
                        push      = 1'b1;
                        wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                    : wr_ptr_ff + PTR_W'(1);
                        fill_in   = fill_ff + CNT_W'(1);
                     end
                  end
               end else begin
                  frame_index_in = next_pos;
               end
            end
            sfr_pkg::ACT_TICK: begin
               if (timer_armed_ff) begin
                  timer_count_in = tick_count;
                  if (tick_count >= timeout_ticks_ff) begin
                     frame_index_in = 4'd0;
                     timer_armed_in = 1'b0;
                  end
               end
            end
            sfr_pkg::ACT_READ: begin
               if (fill_ff != '0) begin
                  pop                     = 1'b1;
                  s1_meta_in.record_valid = 1'b1;
                  rd_ptr_in = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                              : rd_ptr_ff + PTR_W'(1);
                  fill_in   = fill_ff - CNT_W'(1);
               end
            end
            default: ;
         endcase
      end

      // The reported count is the fill level after this transfer, kept to three bits.
      fill_ext              = {3'b000, fill_in};
      s1_meta_in.fifo_count = fill_ext[2:0];
   end

   // Record FIFO storage. A pop reads the entry at the read pointer; its data is registered
   // by the RAM read port and is ready while the transfer sits in the result stage.
   sfr_ram #(
      .WIDTH (REC_W),
      .DEPTH (FIFO_DEPTH)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (wr_ptr_ff),
      .wr_data (rec_asm_ff),
      .rd_en   (pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Pipeline stage control. The result stage holds while the output is stalled, and
   // no new read is issued then, so the RAM read data stays put.
   always_comb begin
      s1_valid_in   = req_take || (s1_valid_ff && !s1_move);
      out_valid_in  = s1_move || (out_valid_ff && !rsp_chan.ready);
      out_meta_in   = s1_move ? s1_meta_ff : out_meta_ff;
      out_record_in = out_record_ff;
      if (s1_move) begin
         out_record_in = s1_meta_ff.record_valid ? ram_rd_data : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_index_ff <= 4'd0;
         crc_ff         <= sfr_pkg::CRC_INIT;
         timer_count_ff <= 16'd0;
         timer_armed_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         fill_ff        <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         frame_index_ff <= frame_index_in;
         crc_ff         <= crc_in;
         timer_count_ff <= timer_count_in;
         timer_armed_ff <= timer_armed_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         fill_ff        <= fill_in;
         s1_valid_ff    <= s1_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      rec_asm_ff    <= rec_asm_in;
      crc_lo_ff     <= crc_lo_in;
      count_nib_ff  <= count_nib_in;
      out_meta_ff   <= out_meta_in;
      out_record_ff <= out_record_in;
      if (req_take) begin
         s1_meta_ff <= s1_meta_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.fifo_count     = out_meta_ff.fifo_count;
   assign rsp_chan.record         = out_record_ff;
   assign rsp_chan.record_valid   = out_meta_ff.record_valid;
   assign rsp_chan.frame_accepted = out_meta_ff.frame_accepted;
   assign rsp_chan.frame_dropped  = out_meta_ff.frame_dropped;

endmodule

// ===== hdl/sfr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the sensor frame receiver, attached by the bind below.
// Depends on sensor_frame_receiver_fifo and sfr_pkg.
module sfr_checker #(
   parameter int FIFO_DEPTH = sfr_pkg::FIFO_DEPTH_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  fifo_count,
   input logic [63:0] record,
   input logic        record_valid,
   input logic        frame_accepted,
   input logic        frame_dropped
);

   // A stalled response keeps its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(record) && $stable(fifo_count)
      && $stable(record_valid) && $stable(frame_accepted) && $stable(frame_dropped))
      else $error("response changed while stalled");

   // Without a popped record the record field reads as zero.
   a_record_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !record_valid |-> record == '0)
      else $error("record nonzero without record_valid");

   // A dropped frame was first accepted.
   a_drop_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_dropped |-> frame_accepted)
      else $error("frame dropped without being accepted");

   // A drop only happens while the FIFO stays full.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_dropped |-> fifo_count == 3'(FIFO_DEPTH))
      else $error("frame dropped while FIFO not full");

   // A read and a completed frame never come from the same transfer.
   a_read_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && record_valid |-> !frame_accepted)
      else $error("record read and frame completion in one response");

endmodule

bind sensor_frame_receiver_fifo sfr_checker #(
   .FIFO_DEPTH (FIFO_DEPTH)
) u_sfr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .fifo_count     (rsp_chan.fifo_count),
   .record         (rsp_chan.record),
   .record_valid   (rsp_chan.record_valid),
   .frame_accepted (rsp_chan.frame_accepted),
   .frame_dropped  (rsp_chan.frame_dropped)
);
